// ===== sv/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPA_ASSERT(name, prop, msg)
`define BPA_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int SMALL_ORDER = 12;
  localparam int POOL_ORDER  = 20;
  localparam int REL_TOP     = POOL_ORDER - SMALL_ORDER;
  localparam int PAGE_W      = REL_TOP;
  localparam int NPAGES      = 1 << PAGE_W;
  localparam int ORD_W       = 4;
  localparam int OFF_W       = POOL_ORDER;
  localparam int SIZE_W      = POOL_ORDER + 1;
  localparam logic [ORD_W-1:0] ORDER_TOP  = ORD_W'(REL_TOP);
  localparam logic [ORD_W-1:0] ORDER_NONE = 4'd15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LATCH, OP_SCAN, OP_PICK, OP_SPLIT,
    OP_RDP, OP_CLRP, OP_RDB, OP_MERGE, OP_FEND
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    set_st;
    status_t st;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic misaligned;
    logic cnt_last;
    logic hit;
    logic k_gt_want;
    logic rd_bad;
    logic o_top;
    logic buddy_ok;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/bpa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpa_in_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  block_offset;
  modport source(output valid, action, request_size, block_offset, input ready);
  modport sink(input valid, action, request_size, block_offset, output ready);
endinterface

interface bpa_out_if;
  import bpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] result_offset;
  logic [1:0]       status;
  modport source(output valid, result_offset, status, input ready);
  modport sink(input valid, result_offset, status, output ready);
endinterface
`default_nettype wire

// ===== sv/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over a 1 MiB pool of 4 KiB pages (block orders 12..20).
// Per-page block state lives in a 256 x 5 memory with one read and one write
// port. After reset a pass over all 256 pages initializes it; no item is
// taken meanwhile. An allocate scans all 256 pages, one a cycle, to find the
// lowest-address free block of the smallest fitting order, then splits one
// order a cycle until the block has the wanted order. A free reads the page,
// clears it, then merges with its buddy one order at a time while the buddy is
// free with equal order, up to the whole pool. A bad size or misaligned free is
// rejected at dispatch, any other bad free after its page is read. One item is in
// work at a time; the result register holds a finished result until it is taken.
module buddy_page_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  bpa_in_if.sink    in_if,
  bpa_out_if.source out_if
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_action         (in_if.action),
    .in_request_size   (in_if.request_size),
    .in_block_offset   (in_if.block_offset),
    .out_result_offset (out_if.result_offset),
    .out_status        (out_if.status)
  );
endmodule
`default_nettype wire

// ===== sv/bpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire bpa_pkg::stat_t st,
  output bpa_pkg::cmd_t       cmd
);
  import bpa_pkg::*;

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DISP  = 13'b0000000000100,
    S_SCAN  = 13'b0000000001000,
    S_SCEND = 13'b0000000010000,
    S_PICK  = 13'b0000000100000,
    S_SPLIT = 13'b0000001000000,
    S_FRD   = 13'b0000010000000,
    S_FCHK  = 13'b0000100000000,
    S_MRD   = 13'b0001000000000,
    S_MCHK  = 13'b0010000000000,
    S_FEND  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: OP_NONE, set_st: 1'b0, st: ST_OK, load_out: 1'b0};
    case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (st.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!st.is_free) begin
          if (st.bad_size) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_BAD_SIZE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (st.misaligned) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BAD_FREE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (st.cnt_last) state_nxt = S_SCEND;
      end
      S_SCEND: state_nxt = S_PICK;
      S_PICK: begin
        if (!st.hit) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = OP_PICK;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.op = OP_SPLIT;
        if (!st.k_gt_want) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_FRD: begin
        cmd.op    = OP_RDP;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (st.rd_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BAD_FREE;
          state_nxt  = S_DONE;
        end else begin
          cmd.op    = OP_CLRP;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        if (st.o_top) begin
          state_nxt = S_FEND;
        end else begin
          cmd.op    = OP_RDB;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (st.buddy_ok) begin
          cmd.op    = OP_MERGE;
          state_nxt = S_MRD;
        end else begin
          state_nxt = S_FEND;
        end
      end
      S_FEND: begin
        cmd.op     = OP_FEND;
        cmd.set_st = 1'b1;
        cmd.st     = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BPA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready after accept")
  `BPA_ASSERT_NEXT(a_done_shows, cmd.load_out, out_valid, "result not presented")
  `BPA_ASSERT(a_st_to_done, !cmd.set_st || state_nxt == S_DONE, "status set outside finish")
endmodule
`default_nettype wire

// ===== sv/bpa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpa_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bpa_pkg::cmd_t             cmd,
  output bpa_pkg::stat_t                 st,
  input  wire logic                      in_action,
  input  wire logic [bpa_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [bpa_pkg::OFF_W-1:0]  in_block_offset,
  output logic [bpa_pkg::OFF_W-1:0]      out_result_offset,
  output logic [1:0]                     out_status
);
  import bpa_pkg::*;

  // entry: {free, order}; order 15 means the page heads no block
  logic [ORD_W:0]    mem [NPAGES];
  logic [ORD_W:0]    rd_q_r;
  logic              wr_en, rd_en;
  logic [PAGE_W-1:0] wr_addr, rd_addr;
  logic [ORD_W:0]    wr_data;

  logic [PAGE_W-1:0] cnt_r, p_r, best_r, pend_page_r;
  logic [ORD_W-1:0]  want_r, k_r, o_r, best_ord_r;
  logic              action_r, bad_size_r, misal_r, hit_r, pend_r;
  status_t           res_st_r;
  logic [OFF_W-1:0]  res_off_r, out_off_r;
  logic [1:0]        out_st_r;

  logic [OFF_W-1:0]  size_m1;
  logic [ORD_W-1:0]  want_c, k_dec, q_ord;
  logic [PAGE_W-1:0] buddy;
  logic              q_free, eval_take;

  function automatic logic [ORD_W-1:0] bitlen(input logic [PAGE_W-1:0] v);
    logic [ORD_W-1:0] n;
    n = '0;
    for (int i = 0; i < PAGE_W; i++) begin
      if (v[i]) n = ORD_W'(i + 1);
    end
    return n;
  endfunction

  assign size_m1 = OFF_W'(in_request_size - SIZE_W'(1));
  assign want_c  = bitlen(size_m1[OFF_W-1:SMALL_ORDER]);
  assign k_dec   = k_r - ORD_W'(1);
  assign buddy   = p_r ^ (PAGE_W'(1) << o_r);
  assign q_ord   = rd_q_r[ORD_W-1:0];
  assign q_free  = rd_q_r[ORD_W];

  // scan keeps the first free block of the smallest fitting order
  assign eval_take = pend_r && q_free && (q_ord <= ORDER_TOP) && (q_ord >= want_r)
                     && (!hit_r || q_ord < best_ord_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_r;
    wr_data = {1'b0, ORDER_NONE};
    rd_en   = 1'b0;
    rd_addr = p_r;
    case (cmd.op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = (cnt_r == '0) ? {1'b1, ORDER_TOP} : {1'b0, ORDER_NONE};
      end
      OP_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = cnt_r;
      end
      OP_SPLIT: begin
        wr_en = 1'b1;
        if (k_r > want_r) begin
          wr_addr = best_r + (PAGE_W'(1) << k_dec);
          wr_data = {1'b1, k_dec};
        end else begin
          wr_addr = best_r;
          wr_data = {1'b0, want_r};
        end
      end
      OP_RDP: rd_en = 1'b1;
      OP_CLRP: wr_en = 1'b1;
      OP_RDB: begin
        rd_en   = 1'b1;
        rd_addr = buddy;
      end
      OP_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = buddy;
      end
      OP_FEND: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, o_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      pend_r <= (cmd.op == OP_SCAN);
      if (cmd.op == OP_INIT || cmd.op == OP_SCAN) cnt_r <= cnt_r + PAGE_W'(1);
      if (cmd.op == OP_LATCH) hit_r <= 1'b0;
      else if (eval_take) hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pend_page_r <= cnt_r;
    if (eval_take) begin
      best_r     <= pend_page_r;
      best_ord_r <= q_ord;
    end
    case (cmd.op)
      OP_LATCH: begin
        action_r   <= in_action;
        want_r     <= want_c;
        p_r        <= in_block_offset[OFF_W-1:SMALL_ORDER];
        bad_size_r <= (in_request_size == '0) ||
                      (in_request_size[SIZE_W-1] && in_request_size[OFF_W-1:0] != '0);
        misal_r    <= (in_block_offset[SMALL_ORDER-1:0] != '0);
      end
      OP_PICK: k_r <= best_ord_r;
      OP_SPLIT: if (k_r > want_r) k_r <= k_dec;
      OP_CLRP: o_r <= q_ord;
      OP_MERGE: begin
        o_r <= o_r + ORD_W'(1);
        if (buddy < p_r) p_r <= buddy;
      end
      default: ;
    endcase
    if (cmd.set_st) begin
      res_st_r  <= cmd.st;
      res_off_r <= (cmd.st == ST_OK && !action_r) ? {best_r, {SMALL_ORDER{1'b0}}} : '0;
    end
    if (cmd.load_out) begin
      out_off_r <= res_off_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_result_offset = out_off_r;
  assign out_status        = out_st_r;

  always_comb begin
    st.is_free    = action_r;
    st.bad_size   = bad_size_r;
    st.misaligned = misal_r;
    st.cnt_last   = (cnt_r == {PAGE_W{1'b1}});
    st.hit        = hit_r;
    st.k_gt_want  = (k_r > want_r);
    st.rd_bad     = (q_ord > ORDER_TOP) || q_free;
    st.o_top      = (o_r == ORDER_TOP);
    st.buddy_ok   = (q_ord == o_r) && q_free;
  end
endmodule
`default_nettype wire
